/* rtl/vfkd_pkg.sv */
`timescale 1ns / 1ps

package vfkd_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned PosW    = 4;
  localparam int unsigned FieldW  = 29;
  localparam int unsigned KindW   = 3;
  localparam int unsigned InDataW = 8;
  // value + bytes_used + field_number + wire_kind + status, padded to bytes
  localparam int unsigned OutDataW = 104;

  localparam logic [PosW-1:0] LastPos   = 4'd9;
  localparam logic [7:0]      TenthMax  = 8'h01;
  localparam logic [6:0]      PayloadMask = 7'h7F;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTrunc    = 2'd1,
    StOverflow = 2'd2,
    StBadKey   = 2'd3
  } status_e;

  // wire types accepted as a valid key
  localparam logic [KindW-1:0] WtVarint = 3'd0;
  localparam logic [KindW-1:0] WtFix64  = 3'd1;
  localparam logic [KindW-1:0] WtLenDel = 3'd2;
  localparam logic [KindW-1:0] WtFix32  = 3'd5;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   used;
    logic [FieldW-1:0] field;
    logic [KindW-1:0]  kind;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] acc_next;
    logic [PosW-1:0]   pos_next;
    result_t           res;
  } step_t;

endpackage

/* rtl/vfkd_step.sv */
`timescale 1ns / 1ps

// One byte of varint decode: merge payload, detect end / errors, split key.
module vfkd_step (
  input  logic [vfkd_pkg::ValueW-1:0] acc_i,
  input  logic [vfkd_pkg::PosW-1:0]   pos_i,
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  input  logic                        key_mode_i,
  output vfkd_pkg::step_t             step_o
);
  import vfkd_pkg::*;

  logic [ValueW-1:0] payload_sh;
  logic [ValueW-1:0] merged;
  logic [PosW-1:0]   used;
  logic              kind_ok;
  logic              key_bad;

  // payload shifted to bit 7*pos; pos never passes LastPos
  always_comb begin
    payload_sh = '0;
    case (pos_i)
      4'd0:    payload_sh[6:0]   = byte_i[6:0] & PayloadMask;
      4'd1:    payload_sh[13:7]  = byte_i[6:0];
      4'd2:    payload_sh[20:14] = byte_i[6:0];
      4'd3:    payload_sh[27:21] = byte_i[6:0];
      4'd4:    payload_sh[34:28] = byte_i[6:0];
      4'd5:    payload_sh[41:35] = byte_i[6:0];
      4'd6:    payload_sh[48:42] = byte_i[6:0];
      4'd7:    payload_sh[55:49] = byte_i[6:0];
      4'd8:    payload_sh[62:56] = byte_i[6:0];
      default: payload_sh[63]    = byte_i[0];
    endcase
  end

  assign merged = acc_i | payload_sh;
  assign used   = pos_i + 4'd1;

  always_comb begin
    case (merged[KindW-1:0])
      WtVarint, WtFix64, WtLenDel, WtFix32: kind_ok = 1'b1;
      default:                              kind_ok = 1'b0;
    endcase
  end

  // field = value >> 3: zero, or above 2^29-1 when any of bits 63:32 is set
  assign key_bad = !kind_ok || (merged[31:3] == '0) || (merged[63:32] != '0);

  always_comb begin
    step_o            = '0;
    step_o.res.used   = used;
    step_o.res.status = StOk;
    if ((pos_i == LastPos) && (byte_i > TenthMax)) begin
      step_o.emit       = 1'b1;
      step_o.res.status = StOverflow;
    end else if (byte_i[7]) begin
      if (last_i) begin
        step_o.emit       = 1'b1;
        step_o.res.status = StTrunc;
      end else begin
        step_o.acc_next = merged;
        step_o.pos_next = used;
      end
    end else begin
      step_o.emit = 1'b1;
      if (key_mode_i && key_bad) begin
        step_o.res.status = StBadKey;
      end else begin
        step_o.res.value = merged;
        if (key_mode_i) begin
          step_o.res.field = merged[31:3];
          step_o.res.kind  = merged[KindW-1:0];
        end
      end
    end
  end

endmodule

/* rtl/varint_field_key_decoder.sv */
`timescale 1ns / 1ps

// Base-128 varint decoder, one wire byte per item on the slave side, taking
// one byte every clock unless a held result stalls input. Each byte is
// decoded in the cycle it is accepted: the byte merges into the running
// accumulator, and a byte with a clear top bit (or an error) loads the result
// register, which shows the result on the master side the next cycle. A new
// byte is taken while a result waits as long as the result register is being
// drained; only a held result blocks input. tlast on a byte means no more
// bytes follow; a continuation byte with tlast ends the varint as truncated.
// A tenth byte above 0x01 is overflow. With key_mode set, the finished value
// is also split into field number (value >> 3) and wire type (value & 7), and
// bad keys report status 3. The user must write key_mode through cfg_we_i /
// cfg_wdata_i while idle only; the block itself does not enforce it.
module varint_field_key_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: key_mode
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // byte input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [vfkd_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] wire_byte
  input  logic                          s_axis_tlast,  // final_available
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] varint_value, [67:64] bytes_used, [96:68] field_number,
  // [99:97] wire_kind, [101:100] status, [103:102] zero
  output logic [vfkd_pkg::OutDataW-1:0] m_axis_tdata
);
  import vfkd_pkg::*;

  logic              key_mode_q;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q;
  step_t             step;
  logic              in_fire;

  vfkd_step u_step (
    .acc_i      (acc_q),
    .pos_i      (pos_q),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .key_mode_i (key_mode_q),
    .step_o     (step)
  );

  // input may enter whenever the result register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    acc_d       = acc_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (in_fire) begin
      acc_d = step.acc_next;
      pos_d = step.pos_next;
      if (step.emit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q  <= 1'b0;
      acc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_mode_q <= cfg_wdata_i;
      end
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on a closing byte
  always_ff @(posedge clk_i) begin
    if (in_fire && step.emit) begin
      res_q <= step.res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.status, res_q.kind, res_q.field,
                          res_q.used, res_q.value};

  // byte position stays within a ten byte varint
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= LastPos)
    else $error("byte position past tenth byte");

  // a closing byte restarts the varint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && step.emit) |=> (pos_q == '0) && (acc_q == '0))
    else $error("state not cleared after result");

  // error results carry zero value and key fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.status != StOk)) |->
      ((res_q.value == '0) && (res_q.field == '0) && (res_q.kind == '0)))
    else $error("nonzero payload on error result");

  // a held result blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && !m_axis_tready))
    else $error("input stalled without a held result");

endmodule
